// File: hdl/sdp_pkg.sv
// Shared widths, fixed-point constants and helper functions for the destination point pipeline.
`default_nettype none
package sdp_pkg;

   localparam int Q_FRAC = 30;
   localparam int VAL_W  = 36;
   localparam int TRIG_W = 33;
   localparam int PROD_W = 66;
   localparam int SQ_W   = 62;
   localparam int ROOT_W = 31;

   localparam logic signed [VAL_W-1:0]  GAIN_INV = 36'sd652032874;
   localparam logic signed [TRIG_W-1:0] ONE_Q    = 33'sd1073741824;
   localparam logic signed [PROD_W-1:0] RND_HALF = 66'sd536870912;
   localparam logic [SQ_W-1:0]          ONE_SQ   = 62'h1000_0000_0000_0000;

   // Q30 product, rounded half up
   function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
                                                     input logic signed [TRIG_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b) + RND_HALF;
      return TRIG_W'(p >>> Q_FRAC);
   endfunction

   // Restoring long division, used only while building constants
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] r;
      quo = '0;
      r   = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r      = r - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) in Q62 radians by the alternating series
   function automatic logic [63:0] atan_recip_q62(input logic [63:0] n);
      logic [63:0]        t;
      logic [63:0]        term;
      logic signed [63:0] s;
      t = udiv64(64'h4000_0000_0000_0000, n);
      s = '0;
      for (int k = 0; k < 64; k++) begin
         if (t != '0) begin
            term = udiv64(t, 64'(2 * k + 1));
            if (k[0]) s = s - signed'(term);
            else      s = s + signed'(term);
            t = udiv64(udiv64(t, n), n);
         end
      end
      return s;
   endfunction

   // atan(2^-idx) as a binary angle of ab bits per turn, rounded to nearest
   function automatic logic [63:0] atan_turns(input int ab, input int idx);
      logic [63:0] pi4;
      logic [63:0] rad;
      logic [63:0] q;
      logic [63:0] rem;
      pi4 = (atan_recip_q62(64'd5) << 2) - atan_recip_q62(64'd239);
      if (idx == 0) rad = pi4;
      else          rad = atan_recip_q62(64'd1 << idx);
      q   = '0;
      rem = rad;
      if (rem >= pi4) begin
         rem = rem - pi4;
         q   = 64'd1;
      end
      for (int b = 0; b < ab - 2; b++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= pi4) begin
            rem  = rem - pi4;
            q[0] = 1'b1;
         end
      end
      return (q + 64'd1) >> 1;
   endfunction

endpackage
`default_nettype wire

// File: hdl/sdp_delay.sv
// Enabled shift-register delay line for side data that rides along the pipeline.
`default_nettype none
module sdp_delay
   import sdp_pkg::*;
#(
   parameter int W = 32,
   parameter int D = 4
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] sh_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff[0] <= din;
         for (int k = 1; k < D; k++) sh_ff[k] <= sh_ff[k-1];
      end
   end

   assign dout = sh_ff[D-1];

endmodule
`default_nettype wire

// File: hdl/sdp_sincos.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle in Q30.
`default_nettype none
module sdp_sincos
   import sdp_pkg::*;
#(
   parameter int ANGLE_BITS    = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [ANGLE_BITS-1:0]    angle,
   output logic signed [TRIG_W-1:0] sin_val,
   output logic signed [TRIG_W-1:0] cos_val
);

   localparam int ZW = ANGLE_BITS + 1;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1 <<< (ANGLE_BITS - 2));
   localparam logic signed [ZW-1:0] HALF    = ZW'(64'sd1 <<< (ANGLE_BITS - 1));

   logic signed [VAL_W-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [VAL_W-1:0] y_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0]    z_ff [CORDIC_STAGES+1];
   logic                    neg_ff [CORDIC_STAGES+1];
   logic signed [ZW-1:0]    z_raw;
   logic signed [ZW-1:0]    z_in;
   logic                    neg_in;
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   // fold into the right half plane, flip the result back at the end
   always_comb begin
      z_raw  = ZW'(signed'(angle));
      z_in   = z_raw;
      neg_in = 1'b0;
      if (z_raw > QUARTER) begin
         z_in   = z_raw - HALF;
         neg_in = 1'b1;
      end else if (z_raw < -QUARTER) begin
         z_in   = z_raw + HALF;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_INV;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
      localparam logic signed [ZW-1:0] ROM_K = ZW'(atan_turns(ANGLE_BITS, g));
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[g] >= 0) begin
               x_ff[g+1] <= x_ff[g] - (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] + (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] - ROM_K;
            end else begin
               x_ff[g+1] <= x_ff[g] + (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] - (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] + ROM_K;
            end
            neg_ff[g+1] <= neg_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= neg_ff[CORDIC_STAGES] ? TRIG_W'(-y_ff[CORDIC_STAGES])
                                         : TRIG_W'(y_ff[CORDIC_STAGES]);
         cos_ff <= neg_ff[CORDIC_STAGES] ? TRIG_W'(-x_ff[CORDIC_STAGES])
                                         : TRIG_W'(x_ff[CORDIC_STAGES]);
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
`default_nettype wire

// File: hdl/sdp_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module sdp_isqrt
   import sdp_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   rad,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 2;

   logic [SQ_W-1:0]   n_ff    [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      localparam int P = ROOT_W - 1 - g;
      logic [SQ_W-1:0]   n_p;
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;

      if (g == 0) begin : g_first
         assign n_p    = rad;
         assign rem_p  = '0;
         assign root_p = '0;
      end else begin : g_next
         assign n_p    = n_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
      end

      assign rem_sh = {rem_p[REM_W-3:0], n_p[2*P+1 -: 2]};
      assign trial  = {root_p, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[g] <= n_p;
            if (rem_sh >= trial) begin
               rem_ff[g]  <= rem_sh - trial;
               root_ff[g] <= {root_p[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[g]  <= rem_sh;
               root_ff[g] <= {root_p[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

// File: hdl/sdp_atan2.sv
// Pipelined vectoring-mode CORDIC: atan2 of a Q30 vector as a binary angle.
`default_nettype none
module sdp_atan2
   import sdp_pkg::*;
#(
   parameter int ANGLE_BITS    = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VAL_W-1:0] x_in,
   input  logic signed [VAL_W-1:0] y_in,
   output logic [ANGLE_BITS-1:0]   angle
);

   localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));

   logic signed [VAL_W-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [VAL_W-1:0] y_ff [CORDIC_STAGES+1];
   logic [ANGLE_BITS-1:0]   z_ff [CORDIC_STAGES+1];
   logic                    zero_ff [CORDIC_STAGES+1];
   logic [ANGLE_BITS-1:0]   angle_ff;

   // left half plane: mirror through the origin and start half a turn away
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -x_in;
            y_ff[0] <= -y_in;
            z_ff[0] <= HALF;
         end else begin
            x_ff[0] <= x_in;
            y_ff[0] <= y_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
      localparam logic [ANGLE_BITS-1:0] ROM_K = ANGLE_BITS'(atan_turns(ANGLE_BITS, g));
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[g] >= 0) begin
               x_ff[g+1] <= x_ff[g] + (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] - (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] + ROM_K;
            end else begin
               x_ff[g+1] <= x_ff[g] - (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] + (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] - ROM_K;
            end
            zero_ff[g+1] <= zero_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) angle_ff <= zero_ff[CORDIC_STAGES] ? '0 : z_ff[CORDIC_STAGES];
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

// File: hdl/spherical_destination_point_top.sv
// Top level of the spherical destination point pipeline.
//
// Usage: each transfer on the req_ channel carries a centre latitude and
// longitude, an angular radius and a bearing (binary angles, 2^32 per turn).
// The block answers every request with exactly one transfer on the rsp_
// channel: the latitude and longitude of the point at that distance and
// bearing on the sphere, longitude wrapped to [-pi, pi).
// Throughput: one transfer per cycle, sustained while rsp_tready stays high.
// From request to response the data passes the two CORDIC chains in series
// (sine and cosine, then atan2), the 31-stage square root and seven product,
// sum and format stages.
// Reset clears all valid bits; the data path holds no state worth clearing.
// Stall: the whole pipeline freezes while the response register holds a
// transfer that is not taken, and req_tready drops in the same cycle, so
// nothing is lost or repeated. Bubbles advance whenever the output moves.
`default_nettype none
module spherical_destination_point_top
   import sdp_pkg::*;
#(
   parameter int ANGLE_BITS    = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // centre_lat [31:0], centre_lon [63:32], angular_radius [95:64], bearing [127:96]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_lat [31:0], point_lon [63:32]
   output logic [63:0]  rsp_tdata
);

   localparam int AB     = ANGLE_BITS;
   localparam int SC_LAT = CORDIC_STAGES + 2;
   localparam int AT_LAT = CORDIC_STAGES + 2;
   localparam int PIPE_L = SC_LAT + ROOT_W + AT_LAT + 7;

   logic               adv;
   logic [PIPE_L-1:0]  vld_ff;

   // one enable for every stage: advance unless the output is stuck
   assign adv        = !vld_ff[PIPE_L-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[PIPE_L-2:0], req_tvalid};
   end

   // input stage: scale the 32-bit angles to the internal angle width
   logic [AB-1:0] lat_in, lon_in, rad_in, brg_in;
   logic [AB-1:0] lat_s_ff, lon_s_ff, rad_s_ff, brg_s_ff;

   if (AB >= 32) begin : g_in_wide
      assign lat_in = AB'(req_tdata[31:0])   << (AB - 32);
      assign lon_in = AB'(req_tdata[63:32])  << (AB - 32);
      assign rad_in = AB'(req_tdata[95:64])  << (AB - 32);
      assign brg_in = AB'(req_tdata[127:96]) << (AB - 32);
   end else begin : g_in_narrow
      assign lat_in = AB'(req_tdata[31:0]   >> (32 - AB));
      assign lon_in = AB'(req_tdata[63:32]  >> (32 - AB));
      assign rad_in = AB'(req_tdata[95:64]  >> (32 - AB));
      assign brg_in = AB'(req_tdata[127:96] >> (32 - AB));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_s_ff <= lat_in;
         lon_s_ff <= lon_in;
         rad_s_ff <= rad_in;
         brg_s_ff <= brg_in;
      end
   end

   // sine and cosine of latitude, radius and bearing in parallel
   logic signed [TRIG_W-1:0] sl, cl, sr, cr, sa, ca;
   logic [AB-1:0]            lon_sc;

   sdp_sincos #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat (
      .clock(clock), .en(adv), .angle(lat_s_ff), .sin_val(sl), .cos_val(cl));
   sdp_sincos #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_rad (
      .clock(clock), .en(adv), .angle(rad_s_ff), .sin_val(sr), .cos_val(cr));
   sdp_sincos #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_sc_brg (
      .clock(clock), .en(adv), .angle(brg_s_ff), .sin_val(sa), .cos_val(ca));

   sdp_delay #(.W(AB), .D(SC_LAT)) u_lon_dly0 (
      .clock(clock), .en(adv), .din(lon_s_ff), .dout(lon_sc));

   // products: one multiply level per stage
   logic signed [TRIG_W-1:0] m1_a_ff, m2_a_ff, msr_a_ff, cl_a_ff, ca_a_ff, cr_a_ff, sl_a_ff;
   logic [AB-1:0]            lon_a_ff;
   logic signed [TRIG_W-1:0] m1_b_ff, m3_b_ff, ny_b_ff, cr_b_ff, sl_b_ff;
   logic [AB-1:0]            lon_b_ff;
   logic signed [TRIG_W:0]   sum_in;
   logic signed [TRIG_W-1:0] arg_in;
   logic signed [TRIG_W-1:0] arg_c_ff, ny_c_ff, cr_c_ff, sl_c_ff;
   logic [AB-1:0]            lon_c_ff;
   logic [SQ_W-1:0]          sq_d_ff;
   logic signed [TRIG_W-1:0] slarg_d_ff, arg_d_ff, ny_d_ff, cr_d_ff;
   logic [AB-1:0]            lon_d_ff;
   logic [SQ_W-1:0]          rad_e_ff;
   logic signed [TRIG_W:0]   nx_e_ff;
   logic signed [TRIG_W-1:0] arg_e_ff, ny_e_ff;
   logic [AB-1:0]            lon_e_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_a_ff  <= mulq(sl, cr);
         m2_a_ff  <= mulq(cl, sr);
         msr_a_ff <= mulq(sa, sr);
         cl_a_ff  <= cl;
         ca_a_ff  <= ca;
         cr_a_ff  <= cr;
         sl_a_ff  <= sl;
         lon_a_ff <= lon_sc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_b_ff  <= m1_a_ff;
         m3_b_ff  <= mulq(m2_a_ff, ca_a_ff);
         ny_b_ff  <= mulq(msr_a_ff, cl_a_ff);
         cr_b_ff  <= cr_a_ff;
         sl_b_ff  <= sl_a_ff;
         lon_b_ff <= lon_a_ff;
      end
   end

   // clamp the asin argument to [-1, 1]
   always_comb begin
      sum_in = (TRIG_W+1)'(m1_b_ff) + (TRIG_W+1)'(m3_b_ff);
      if (sum_in > (TRIG_W+1)'(ONE_Q))       arg_in = ONE_Q;
      else if (sum_in < -(TRIG_W+1)'(ONE_Q)) arg_in = -ONE_Q;
      else                                   arg_in = TRIG_W'(sum_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         arg_c_ff <= arg_in;
         ny_c_ff  <= ny_b_ff;
         cr_c_ff  <= cr_b_ff;
         sl_c_ff  <= sl_b_ff;
         lon_c_ff <= lon_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_d_ff    <= SQ_W'(PROD_W'(arg_c_ff) * PROD_W'(arg_c_ff));
         slarg_d_ff <= mulq(sl_c_ff, arg_c_ff);
         arg_d_ff   <= arg_c_ff;
         ny_d_ff    <= ny_c_ff;
         cr_d_ff    <= cr_c_ff;
         lon_d_ff   <= lon_c_ff;
      end
   end

   // sin(lat2) is the clamped argument itself
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_e_ff <= ONE_SQ - sq_d_ff;
         nx_e_ff  <= (TRIG_W+1)'(cr_d_ff) - (TRIG_W+1)'(slarg_d_ff);
         arg_e_ff <= arg_d_ff;
         ny_e_ff  <= ny_d_ff;
         lon_e_ff <= lon_d_ff;
      end
   end

   // cos(lat2) by square root; hold the other operands beside it
   logic [ROOT_W-1:0]            root;
   logic [3*TRIG_W:0]            side_in, side_out;
   logic signed [TRIG_W-1:0]     arg_q, ny_q;
   logic signed [TRIG_W:0]       nx_q;
   logic [AB-1:0]                lon_q;

   sdp_isqrt u_isqrt (.clock(clock), .en(adv), .rad(rad_e_ff), .root(root));

   assign side_in = {arg_e_ff, ny_e_ff, nx_e_ff};
   sdp_delay #(.W(3*TRIG_W+1), .D(ROOT_W)) u_side_dly (
      .clock(clock), .en(adv), .din(side_in), .dout(side_out));
   assign arg_q = side_out[3*TRIG_W -: TRIG_W];
   assign ny_q  = side_out[2*TRIG_W -: TRIG_W];
   assign nx_q  = side_out[TRIG_W:0];

   sdp_delay #(.W(AB), .D(ROOT_W + AT_LAT)) u_lon_dly1 (
      .clock(clock), .en(adv), .din(lon_e_ff), .dout(lon_q));

   // latitude and longitude offset by atan2
   logic [AB-1:0] lat2, dlon, lon2;

   sdp_atan2 #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_at_lat (
      .clock(clock), .en(adv),
      .x_in(VAL_W'({1'b0, root})), .y_in(VAL_W'(arg_q)), .angle(lat2));
   sdp_atan2 #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_at_lon (
      .clock(clock), .en(adv),
      .x_in(VAL_W'(nx_q)), .y_in(VAL_W'(ny_q)), .angle(dlon));

   assign lon2 = lon_q + dlon;

   // back to 32 bits per turn, rounding half up when narrowing
   logic [31:0] lat_out, lon_out;
   logic [63:0] rsp_ff;

   if (AB > 32) begin : g_out_wide
      localparam logic [AB:0] RND = (AB+1)'(64'd1 << (AB - 33));
      assign lat_out = 32'(({1'b0, lat2} + RND) >> (AB - 32));
      assign lon_out = 32'(({1'b0, lon2} + RND) >> (AB - 32));
   end else begin : g_out_narrow
      assign lat_out = 32'(lat2) << (32 - AB);
      assign lon_out = 32'(lon2) << (32 - AB);
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= {lon_out, lat_out};
   end

   assign rsp_tvalid = vld_ff[PIPE_L-1];
   assign rsp_tdata  = rsp_ff;

   // a stalled pipeline keeps every valid bit in place
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid chain moved during a stall");

   // an accepted request occupies the first stage
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted request lost at the input stage");

   // result latitude stays near the poles at most
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:0]) <= 32'sd1090519040 &&
                      $signed(rsp_tdata[31:0]) >= -32'sd1090519040))
      else $error("latitude beyond the poles");

endmodule
`default_nettype wire

// File: test/testbench.sv
// Testbench for the spherical destination point pipeline: random and directed stream traffic.
`timescale 1ns / 1ps
`default_nettype none

// Tracks requests in flight and checks each response against a bit-exact model.
class destination_scoreboard;
   typedef struct {
      logic signed [31:0] point_lat;
      logic signed [31:0] point_lon;
   } point_type;

   localparam int STAGES = 30;

   point_type pending[$];
   longint rom[STAGES];
   int     failures;

   function new();
      longint unsigned pi4;
      failures = 0;
      pi4 = 4 * atan_inv(5) - atan_inv(239);
      for (int i = 0; i < STAGES; i++)
         rom[i] = to_turns(i == 0 ? pi4 : atan_inv(64'd1 << i), pi4);
   endfunction

   // atan(1/n) in Q62 radians by the alternating series
   function longint unsigned atan_inv(longint unsigned n);
      longint unsigned t;
      longint unsigned k;
      longint          s;
      t = (64'd1 << 62) / n;
      s = 0;
      k = 0;
      while (t != 0) begin
         if (k[0]) s = s - longint'(t / (2 * k + 1));
         else      s = s + longint'(t / (2 * k + 1));
         t = t / n / n;
         k++;
      end
      return s;
   endfunction

   // Q62 radians to a 32-bit binary angle, rounded to nearest
   function longint to_turns(longint unsigned rad, longint unsigned pi4);
      longint unsigned q;
      longint unsigned rem;
      q   = 0;
      rem = rad;
      if (rem >= pi4) begin
         rem -= pi4;
         q = 1;
      end
      for (int b = 0; b < 30; b++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= pi4) begin
            rem -= pi4;
            q |= 1;
         end
      end
      return longint'((q + 1) >> 1);
   endfunction

   function longint wrap_angle(longint v);
      logic [63:0] w;
      w = v;
      return longint'(signed'(w[31:0]));
   endfunction

   function longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function void rotate(logic [31:0] ang, output longint sn, output longint cs);
      longint z;
      longint x;
      longint y;
      longint dx;
      bit     flip;
      z    = longint'(signed'(ang));
      x    = 652032874;
      y    = 0;
      flip = 0;
      if (z > (64'sd1 <<< 30)) begin
         z -= (64'sd1 <<< 31);
         flip = 1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z += (64'sd1 <<< 31);
         flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         if (z >= 0) begin
            y = y + (x >>> i);
            x = x - dx;
            z = z - rom[i];
         end else begin
            y = y - (x >>> i);
            x = x + dx;
            z = z + rom[i];
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function longint vector_angle(longint y, longint x);
      longint z;
      longint dx;
      if (x == 0 && y == 0) return 0;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd1 <<< 31;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         if (y >= 0) begin
            y = y - (x >>> i);
            x = x + dx;
            z = z + rom[i];
         end else begin
            y = y + (x >>> i);
            x = x - dx;
            z = z - rom[i];
         end
      end
      return wrap_angle(z);
   endfunction

   function longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned bt;
      r  = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
         if (n >= r + bt) begin
            n = n - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r = r >> 1;
         end
         bt = bt >> 2;
      end
      return r;
   endfunction

   function point_type predict_point(logic [127:0] d);
      longint sl, cl, sr, cr, sa, ca, arg, lat2, ny, nx;
      point_type p;
      rotate(d[31:0], sl, cl);
      rotate(d[95:64], sr, cr);
      rotate(d[127:96], sa, ca);
      arg = qmul(sl, cr) + qmul(qmul(cl, sr), ca);
      // clamp the asin argument to [-1, 1]
      if (arg > (64'sd1 <<< 30)) arg = 64'sd1 <<< 30;
      if (arg < -(64'sd1 <<< 30)) arg = -(64'sd1 <<< 30);
      lat2 = vector_angle(arg, longint'(floor_root((64'd1 << 60) - arg * arg)));
      ny = qmul(qmul(sa, sr), cl);
      nx = cr - qmul(sl, arg);
      p.point_lat = lat2[31:0];
      p.point_lon = d[63:32] + 32'(vector_angle(ny, nx));
      return p;
   endfunction

   function void note_request(logic [127:0] d);
      pending.push_back(predict_point(d));
   endfunction

   function void check_response(logic [63:0] d);
      point_type p;
      if (pending.size() == 0) begin
         $error("unexpected response %h", d);
         failures++;
         return;
      end
      p = pending.pop_front();
      if (d[31:0] !== p.point_lat) begin
         $error("point_lat expected %0d got %0d", p.point_lat, signed'(d[31:0]));
         failures++;
      end
      if (d[63:32] !== p.point_lon) begin
         $error("point_lon expected %0d got %0d", p.point_lon, signed'(d[63:32]));
         failures++;
      end
   endfunction
endclass

module testbench;
   localparam int RANDOM_ITEMS = 1700;
   localparam logic [31:0] QUARTER = 32'h4000_0000;
   localparam logic [31:0] HALF    = 32'h8000_0000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   bit           calm;       // set during the stretch where neither side idles
   bit           done;

   destination_scoreboard points = new();

   spherical_destination_point_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Hold the response side ready at random; during the calm stretch never stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 21);
      end
   end

   // Sample handshakes mid-cycle, where all inputs and outputs are settled.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) points.check_response(rsp_tdata);
   end

   // Offer one request, idle first at random, and hold it until the transfer.
   task automatic send_point(logic [31:0] lat, logic [31:0] lon, logic [31:0] rad,
                             logic [31:0] az);
      bit fire;
      while (!calm && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, rad, lon, lat};
      do begin
         @(negedge clock);
         fire = req_tready;
         if (fire) points.note_request(req_tdata);
         @(posedge clock);
      end while (!fire);
   endtask

   // Latitude within [-pi/2, pi/2], now and then any angle at all.
   function automatic logic [31:0] pick_lat();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, HALF) - QUARTER;
   endfunction

   function automatic logic [31:0] pick_radius();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0010_0000);
         default: return $urandom_range(0, HALF);
      endcase
   endfunction

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      done       = 1'b0;
      reset      = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes
      send_point(0, 0, 0, 0);
      send_point(QUARTER, 32'h7fff_ffff, HALF, 32'hffff_ffff);
      send_point(-QUARTER, HALF, HALF, 0);
      send_point(32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555);
      // poles: clamped asin argument and atan2 of zero and zero
      send_point(QUARTER, 0, 0, 0);
      send_point(-QUARTER, 32'h1234_5678, 0, HALF);
      send_point(QUARTER, 0, 32'h0000_0001, 0);
      send_point(QUARTER - 1, 0, 32'h0000_0010, 0);
      send_point(-QUARTER, 0, HALF, QUARTER);
      // longitude wrap both ways
      send_point(0, 32'h7fff_ff00, 32'h0100_0000, QUARTER);
      send_point(0, HALF, 32'h0100_0000, 32'hc000_0000);
      send_point(32'h2000_0000, 32'h7fff_ffff, HALF, QUARTER);
      // antipode and cardinal bearings
      send_point(32'h1000_0000, 32'h2000_0000, HALF, 32'h2000_0000);
      send_point(32'h1000_0000, 0, QUARTER, HALF);
      send_point(32'hf000_0000, 0, QUARTER, 32'hc000_0000);
      send_point(0, 0, 32'h0000_0001, 32'h8000_0001);

      // random part: footprint sweeps around a centre, with loose points between
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         logic [31:0] lat;
         logic [31:0] lon;
         logic [31:0] rad;
         calm = (n >= 700 && n < 1000);
         lat  = pick_lat();
         lon  = $urandom;
         rad  = pick_radius();
         if ($urandom_range(0, 3) == 0) begin
            send_point(lat, lon, rad, $urandom);
         end else begin
            for (int s = 0; s < 8 && n < RANDOM_ITEMS; s++, n++)
               send_point(lat, lon, rad, s * 32'h2000_0000 + $urandom_range(0, 255));
            n--;
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (points.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      done = 1'b1;
      if (points.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      if (!done) begin
         $display("Regression FAIL");
         $finish;
      end
   end
endmodule

`default_nettype wire
